### sv/sas_pkg.sv
// Shared types and constants for the stepper angle sequencer.
// No dependencies; every other file refers to it by scoped names.
package sas_pkg;

   // Degrees per full step and one full shaft turn.
   localparam int STEP_ANGLE = 90;
   localparam int FULL_TURN = 360;

   localparam int ANGLE_W = 9;
   localparam int TICKS_W = 16;
   localparam int STEPS_W = 16;

   localparam logic [TICKS_W-1:0] PHASE_TICKS_RESET = 16'd100;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_ABS  = 2'd1,
      KIND_CW   = 2'd2,
      KIND_CCW  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] target_angle;
      logic [15:0]        move_angle;
   } req_type;

   typedef struct packed {
      logic [3:0]         coils;
      logic               busy_res;
      logic [ANGLE_W-1:0] shaft_angle;
      logic               move_done;
      logic               rejected;
   } rsp_type;

   // Input word after the state-independent arithmetic.
   typedef struct packed {
      kind_type           kind;
      logic [ANGLE_W-1:0] target_norm;  // target mod 360
      logic [STEPS_W-1:0] rel_steps;    // move_angle / STEP_ANGLE
      logic [ANGLE_W-1:0] rel_mod;      // move_angle mod 360
      logic [15:0]        move_angle;
   } dec_type;

endpackage

### sv/sas_decode.sv
// Input register of the stepper sequencer: accepts request words and stores them
// with the target reduced mod 360 and the relative step count. Uses sas_pkg.
module sas_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sas_pkg::req_type req_word,
   input  logic             advance,
   output logic             dec_valid,
   output sas_pkg::dec_type dec_word
);

   // Reciprocal for an exact floor(x / STEP_ANGLE) over 16-bit x.
   localparam int STEP_SHIFT = 16 + $clog2(sas_pkg::STEP_ANGLE);
   localparam logic [16:0] RECIP =
      17'(((64'd1 << STEP_SHIFT) + 64'(sas_pkg::STEP_ANGLE) - 64'd1) /
          64'(sas_pkg::STEP_ANGLE));
   // Multiple of 360 that lifts any signed 16-bit target above zero.
   localparam int TARGET_BIAS =
      sas_pkg::FULL_TURN * ((32768 + sas_pkg::FULL_TURN - 1) / sas_pkg::FULL_TURN);

   logic             valid_ff, valid_in;
   sas_pkg::dec_type dec_ff, dec_in;
   logic             take;
   logic [17:0]      biased;
   logic [47:0]      rel_prod;

   // x mod 360 for x below 360 * 256: eight compare-subtract steps.
   function automatic logic [8:0] mod_turn(input logic [16:0] x);
      logic [16:0] r;
      r = x;
      for (int k = 7; k >= 0; k--) begin
         if (r >= 17'(sas_pkg::FULL_TURN << k)) begin
            r = r - 17'(sas_pkg::FULL_TURN << k);
         end
      end
      return r[8:0];
   endfunction

   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;
   assign dec_valid = valid_ff;
   assign dec_word  = dec_ff;

   always_comb begin
      biased   = {{2{req_word.target_angle[15]}}, req_word.target_angle} +
                 18'(TARGET_BIAS);
      rel_prod = 48'(req_word.move_angle) * 48'(RECIP);

      dec_in.kind        = req_word.kind;
      dec_in.target_norm = mod_turn(biased[16:0]);
      dec_in.rel_steps   = rel_prod[STEP_SHIFT +: 16];
      dec_in.rel_mod     = mod_turn({1'b0, req_word.move_angle});
      dec_in.move_angle  = req_word.move_angle;

      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         dec_ff <= dec_in;
      end
   end

endmodule

### sv/sas_core.sv
// Sequencer state, phase timing and result register of the stepper sequencer.
// Uses sas_pkg; fed by sas_decode.
module sas_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             dec_valid,
   input  sas_pkg::dec_type dec_word,
   output logic             advance,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sas_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);

   localparam logic [3:0] COIL_TABLE [4] = '{4'hC, 4'h6, 4'h3, 4'h9};
   localparam logic [8:0] STEP_W = 9'(sas_pkg::STEP_ANGLE);
   localparam logic [9:0] TURN_W = 10'(sas_pkg::FULL_TURN);
   localparam int ABS_QW = $clog2(sas_pkg::FULL_TURN / sas_pkg::STEP_ANGLE + 1);

   logic [8:0]             angle_now_ff, angle_now_in;
   logic [8:0]             angle_after_ff, angle_after_in;
   logic [15:0]            steps_left_ff, steps_left_in;
   logic [1:0]             phase_ff, phase_in;
   logic [15:0]            hold_ff, hold_in;
   logic                   ccw_ff, ccw_in;
   logic                   moving_ff, moving_in;
   logic [15:0]            phase_ticks_ff, phase_ticks_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   sas_pkg::rsp_type       rsp_word_ff, rsp_word_in;

   logic [9:0]             diff;
   logic [8:0]             mag;
   logic [9:0]             abs_rem;
   logic [ABS_QW-1:0]      abs_q;
   logic [24:0]            rel_prod;
   logic [8:0]             rel_rem;
   logic [9:0]             rel_dist;
   logic [15:0]            start_steps;
   logic [8:0]             start_dist;
   logic                   start_ccw;
   logic [9:0]             cw_sum;
   logic [9:0]             ccw_sum;
   logic [15:0]            limit;
   logic [15:0]            hold_next;
   logic [15:0]            steps_dec;
   logic                   done;
   logic                   rej;

   assign advance   = dec_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      angle_now_in   = angle_now_ff;
      angle_after_in = angle_after_ff;
      steps_left_in  = steps_left_ff;
      phase_in       = phase_ff;
      hold_in        = hold_ff;
      ccw_in         = ccw_ff;
      moving_in      = moving_ff;
      phase_ticks_in = csr_valid ? csr_data : phase_ticks_ff;
      done           = 1'b0;
      rej            = 1'b0;

      // absolute move: signed distance, then quotient and remainder by STEP_ANGLE
      diff = {1'b0, dec_word.target_norm} - {1'b0, angle_now_ff};
      mag  = diff[9] ? 9'(-diff) : diff[8:0];
      abs_rem = {1'b0, mag};
      abs_q   = '0;
      for (int k = ABS_QW - 1; k >= 0; k--) begin
         if (19'(abs_rem) >= 19'(sas_pkg::STEP_ANGLE << k)) begin
            abs_rem  = 10'(19'(abs_rem) - 19'(sas_pkg::STEP_ANGLE << k));
            abs_q[k] = 1'b1;
         end
      end

      // relative move: turn distance = (angle mod 360 - angle mod step) mod 360
      rel_prod = 25'(dec_word.rel_steps) * 25'(STEP_W);
      rel_rem  = 9'(dec_word.move_angle - rel_prod[15:0]);
      rel_dist = {1'b0, dec_word.rel_mod} - {1'b0, rel_rem};
      if (rel_dist[9]) begin
         rel_dist = rel_dist + TURN_W;
      end

      if (dec_word.kind == sas_pkg::KIND_ABS) begin
         start_steps = 16'(abs_q);
         start_dist  = mag - abs_rem[8:0];
         start_ccw   = diff[9];
      end else begin
         start_steps = dec_word.rel_steps;
         start_dist  = rel_dist[8:0];
         start_ccw   = (dec_word.kind == sas_pkg::KIND_CCW);
      end

      cw_sum = {1'b0, angle_now_ff} + {1'b0, start_dist};
      if (cw_sum >= TURN_W) begin
         cw_sum = cw_sum - TURN_W;
      end
      ccw_sum = {1'b0, angle_now_ff} + TURN_W - {1'b0, start_dist};
      if (ccw_sum >= TURN_W) begin
         ccw_sum = ccw_sum - TURN_W;
      end

      limit     = (phase_ticks_ff == '0) ? 16'd1 : phase_ticks_ff;
      hold_next = hold_ff + 16'd1;
      steps_dec = steps_left_ff - 16'd1;

      if (advance) begin
         case (dec_word.kind)
            sas_pkg::KIND_TICK: begin
               if (moving_ff) begin
                  hold_in = hold_next;
                  if (hold_next >= limit || hold_next == '0) begin
                     hold_in = '0;
                     if (phase_ff == 2'd3) begin
                        phase_in      = 2'd0;
                        steps_left_in = steps_dec;
                        if (steps_dec == '0) begin
                           moving_in    = 1'b0;
                           angle_now_in = angle_after_ff;
                           done         = 1'b1;
                        end
                     end else begin
                        phase_in = phase_ff + 2'd1;
                     end
                  end
               end
            end
            default: begin
               if (moving_ff) begin
                  rej = 1'b1;
               end else if (start_steps == '0) begin
                  // covers an absolute target equal to the current angle
                  done = 1'b1;
               end else begin
                  angle_after_in = start_ccw ? ccw_sum[8:0] : cw_sum[8:0];
                  steps_left_in  = start_steps;
                  phase_in       = 2'd0;
                  hold_in        = '0;
                  ccw_in         = start_ccw;
                  moving_in      = 1'b1;
               end
            end
         endcase
      end

      rsp_word_in.coils       = moving_in ?
                                COIL_TABLE[ccw_in ? (2'd3 - phase_in) : phase_in] : 4'd0;
      rsp_word_in.busy_res    = moving_in;
      rsp_word_in.shaft_angle = angle_now_in;
      rsp_word_in.move_done   = done;
      rsp_word_in.rejected    = rej;

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_now_ff   <= '0;
         angle_after_ff <= '0;
         steps_left_ff  <= '0;
         phase_ff       <= '0;
         hold_ff        <= '0;
         ccw_ff         <= 1'b0;
         moving_ff      <= 1'b0;
         phase_ticks_ff <= sas_pkg::PHASE_TICKS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         angle_now_ff   <= angle_now_in;
         angle_after_ff <= angle_after_in;
         steps_left_ff  <= steps_left_in;
         phase_ff       <= phase_in;
         hold_ff        <= hold_in;
         ccw_ff         <= ccw_in;
         moving_ff      <= moving_in;
         phase_ticks_ff <= phase_ticks_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // a move in progress always has at least one step left
   a_steps_while_moving: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> steps_left_ff != '0)
      else $error("moving with zero steps left");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      angle_now_ff < TURN_W[8:0] && angle_after_ff < TURN_W[8:0])
      else $error("shaft angle out of range");

   a_idle_coils_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_word_ff.busy_res) |-> rsp_word_ff.coils == 4'd0)
      else $error("coils driven while idle");

   a_done_not_rejected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_word_ff.move_done && rsp_word_ff.rejected))
      else $error("word both done and rejected");

   // state moves only when a word is processed
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |->
         $stable(angle_now_ff) && $stable(moving_ff) && $stable(hold_ff))
      else $error("state changed without a word");

endmodule

### sv/stepper_angle_sequencer.sv
// Top level of the four-coil stepper sequencer with shaft-angle tracking.
// Depends on sas_pkg, sas_decode and sas_core.
//
//  channel | ports                               | moves
//  --------+-------------------------------------+-------------------------------
//  req     | req_valid, req_stall, req_word      | tick or move command word in
//  rsp     | rsp_valid, rsp_stall, rsp_word      | one result word per request word
//  csr     | csr_valid, csr_ready, csr_data      | phase_ticks write (always ready)
//
// One word per cycle sustained while rsp_stall is low; a request passes through the
// input register in sas_decode and then the result register in sas_core.
// Synchronous active-high reset: idle, angle 0, phase_ticks 100.
// rsp_stall holds the result register; the input register still takes one more
// word, then req_stall rises until the result is taken.
module stepper_angle_sequencer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sas_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sas_pkg::rsp_type rsp_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data
);

   // decoded word and the hand-off between the two stages
   logic             dec_valid;
   sas_pkg::dec_type dec_word;
   logic             advance;

   // input register: mod-360 reduction and step count by reciprocal multiply
   sas_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .advance   (advance),
      .dec_valid (dec_valid),
      .dec_word  (dec_word)
   );

   // sequencer state, phase hold counter, coil lookup, result register
   sas_core u_core (
      .clock     (clock),
      .reset     (reset),
      .dec_valid (dec_valid),
      .dec_word  (dec_word),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

endmodule
